### rtl/s3m_pattern_cell_converter_unit_defines.svh
// Assertion helpers used by the converter unit RTL
`ifndef S3M_PATTERN_CELL_CONVERTER_UNIT_DEFINES_SVH
`define S3M_PATTERN_CELL_CONVERTER_UNIT_DEFINES_SVH

// Implication checked every clock outside reset
`define S3M_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s3m check failed");

// Next-cycle implication checked every clock outside reset
`define S3M_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s3m check failed");

`endif

### rtl/s3m_pkg.sv
package s3m_pkg;

  localparam int NumChannels    = 32;
  localparam int MaxInstrument  = 128;
  localparam int RowsPerPattern = 64;
  localparam int ChW            = 5;

  typedef enum logic [2:0] {
    PH_MASK  = 3'd0,
    PH_NOTE  = 3'd1,
    PH_INSTR = 3'd2,
    PH_VOL   = 3'd3,
    PH_EFX   = 3'd4,
    PH_PARAM = 3'd5
  } phase_t;

  // Collected cell handed from the parser to the converter
  typedef struct packed {
    logic [5:0] row;
    logic [4:0] channel;
    logic [7:0] mask;
    logic [7:0] note_raw;
    logic [7:0] instr_raw;
    logic [7:0] vol_raw;
    logic [7:0] effect_raw;
    logic [7:0] param;
  } cell_t;

  // Per-channel memory word
  typedef struct packed {
    logic [7:0] last_param;
    logic [7:0] last_effect;
    logic [7:0] last_vib;
    logic [7:0] last_porta_ins;
  } chmem_t;

endpackage

### rtl/s3m_pattern_cell_converter_unit.sv
// Channel | Ports                                   | Direction
// in      | in_valid, in_stall, in_data_byte, ...   | byte stream in
// out     | out_valid, out_stall, out_row, ...      | converted cell out
//
// One byte is taken per cycle while in_stall is low; each cell is then queued.
// The per-channel memory is read in stage 1 and written back in stage 2,
// with forwarding between neighbouring cells of the same channel.
// Reset clears parse state and marks all channel memories as zero.
// in_stall rises when the output queue may not absorb cells in flight.
module s3m_pattern_cell_converter_unit #(
  parameter int MAX_INSTRUMENT   = s3m_pkg::MaxInstrument,
  parameter int ROWS_PER_PATTERN = s3m_pkg::RowsPerPattern
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_pattern_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_row,
  output logic [4:0] out_channel,
  output logic [6:0] out_note,
  output logic [7:0] out_instrument,
  output logic [7:0] out_volume,
  output logic [5:0] out_effect,
  output logic [7:0] out_effect_param
);
  import s3m_pkg::*;
  `include "s3m_pattern_cell_converter_unit_defines.svh"

  // Row counter wide enough for any pattern length up to 256 rows
  localparam int RowW = 9;
  localparam int QD   = 4;

  phase_t          ph_r, ph_nxt;
  logic [7:0]      mask_r, note_r, ins_r, vol_r, efx_r;
  logic [RowW-1:0] row_r;
  logic            acc, clr, emit;
  cell_t           pcell;
  logic [7:0]      mask_use;

  assign acc = in_valid && !in_stall;
  assign clr = acc && in_pattern_start;

  // Parse one byte per accepted item
  always_comb begin
    ph_nxt   = ph_r;
    emit     = 1'b0;
    mask_use = mask_r;
    pcell    = '0;
    if (acc) begin
      case (clr ? PH_MASK : ph_r)
        PH_NOTE:  ph_nxt = PH_INSTR;
        PH_INSTR: begin
          if (mask_r[6])      ph_nxt = PH_VOL;
          else if (mask_r[7]) ph_nxt = PH_EFX;
          else begin ph_nxt = PH_MASK; emit = 1'b1; end
        end
        PH_VOL: begin
          if (mask_r[7]) ph_nxt = PH_EFX;
          else begin ph_nxt = PH_MASK; emit = 1'b1; end
        end
        PH_EFX:   ph_nxt = PH_PARAM;
        PH_PARAM: begin ph_nxt = PH_MASK; emit = 1'b1; end
        default: begin
          ph_nxt = PH_MASK;
          if ((clr ? '0 : row_r) < RowW'(ROWS_PER_PATTERN) && in_data_byte != 0) begin
            mask_use = in_data_byte;
            if (in_data_byte[5])      ph_nxt = PH_NOTE;
            else if (in_data_byte[6]) ph_nxt = PH_VOL;
            else if (in_data_byte[7]) ph_nxt = PH_EFX;
            else emit = 1'b1;
          end
        end
      endcase
    end
    pcell.row        = clr ? 6'd0 : row_r[5:0];
    pcell.channel    = mask_use[4:0];
    pcell.mask       = mask_use;
    pcell.note_raw   = (ph_r == PH_MASK || clr) ? 8'd0 : note_r;
    pcell.instr_raw  = (ph_r == PH_INSTR && !clr) ? in_data_byte :
                       ((ph_r == PH_MASK || clr) ? 8'd0 : ins_r);
    pcell.vol_raw    = (ph_r == PH_VOL && !clr) ? in_data_byte :
                       ((ph_r == PH_MASK || clr || ph_r == PH_INSTR) ? 8'd0 : vol_r);
    pcell.effect_raw = (ph_r == PH_PARAM && !clr) ? efx_r : 8'd0;
    pcell.param      = (ph_r == PH_PARAM && !clr) ? in_data_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_MASK;
      row_r  <= '0;
      mask_r <= '0;
    end else if (acc) begin
      ph_r   <= ph_nxt;
      mask_r <= mask_use;
      if ((clr || ph_r == PH_MASK) && in_data_byte == 0 &&
          (clr ? '0 : row_r) < RowW'(ROWS_PER_PATTERN)) begin
        row_r <= (clr ? '0 : row_r) + 1'b1;
      end else if (clr) begin
        row_r <= '0;
      end
    end
  end

  // Hold raw cell bytes
  always_ff @(posedge clk) begin
    if (acc) begin
      if (clr || ph_r == PH_MASK) begin
        note_r <= '0; ins_r <= '0; vol_r <= '0; efx_r <= '0;
      end
      if (ph_r == PH_NOTE && !clr)  note_r <= in_data_byte;
      if (ph_r == PH_INSTR && !clr) ins_r  <= in_data_byte;
      if (ph_r == PH_VOL && !clr)   vol_r  <= in_data_byte;
      if (ph_r == PH_EFX && !clr)   efx_r  <= in_data_byte;
    end
  end

  logic             c_v;
  logic [5:0]       c_row;
  logic [4:0]       c_ch;
  logic [6:0]       c_note;
  logic [7:0]       c_ins, c_vol, c_prm;
  logic [5:0]       c_efx;

  s3m_conv #(.MAX_INSTRUMENT(MAX_INSTRUMENT)) u_conv (
    .clk, .rst_n,
    .clear(clr), .cell_valid(emit), .cell_in(pcell),
    .res_valid(c_v),
    .res_row(c_row), .res_channel(c_ch), .res_note(c_note),
    .res_instrument(c_ins), .res_volume(c_vol), .res_effect(c_efx),
    .res_param(c_prm)
  );

  // Output queue absorbs cells in flight while the sink stalls
  localparam int QW = 6 + 5 + 7 + 8 + 8 + 6 + 8;
  logic [QW-1:0]  q [QD];
  logic [1:0]     wp_r, rp_r;
  logic [2:0]     cnt_r, fl_r;
  logic           pop;
  logic [QW-1:0]  qh;

  assign pop = out_valid && !out_stall;
  always_ff @(posedge clk) begin
    if (c_v) q[wp_r] <= {c_row, c_ch, c_note, c_ins, c_vol, c_efx, c_prm};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; fl_r <= '0;
    end else begin
      if (c_v) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(c_v) - 3'(pop);
      fl_r  <= fl_r + 3'(emit) - 3'(c_v);
    end
  end
  assign qh       = q[rp_r];
  assign out_valid = cnt_r != 0;
  assign {out_row, out_channel, out_note, out_instrument, out_volume, out_effect,
          out_effect_param} = qh;
  // Hold the input only when no queue slot is left for another cell
  assign in_stall = (cnt_r + fl_r) >= 3'(QD);

  `S3M_ASSERT_IMP(a_q_bound, 1'b1, (cnt_r + fl_r) <= 3'(QD))
  `S3M_ASSERT_NXT(a_row_clr, clr && in_data_byte != 0, row_r == '0)
  `S3M_ASSERT_IMP(a_emit_acc, emit, acc)

endmodule

### rtl/s3m_conv.sv
// Cell conversion with per-channel effect memory.
// Stage 1 issues the memory read; stage 2 converts and writes back.
module s3m_conv #(
  parameter int MAX_INSTRUMENT = s3m_pkg::MaxInstrument
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              cell_valid,
  input  s3m_pkg::cell_t    cell_in,
  output logic              res_valid,
  output logic [5:0]        res_row,
  output logic [4:0]        res_channel,
  output logic [6:0]        res_note,
  output logic [7:0]        res_instrument,
  output logic [7:0]        res_volume,
  output logic [5:0]        res_effect,
  output logic [7:0]        res_param
);
  import s3m_pkg::*;

  // Memory and its epoch marks (clear after a new pattern)
  chmem_t             mem [NumChannels];
  chmem_t             rd_r;
  logic               wr_en;
  logic [ChW-1:0]     wr_ch;
  chmem_t             wr_data;
  logic [NumChannels-1:0] valid_r;

  // Stage 2 registers
  logic               s2_v_r;
  cell_t              s2_r;
  logic               s2_hit_r;
  logic               s2_fresh_r;

  // Read memory at stage 1
  always_ff @(posedge clk) begin
    rd_r <= mem[cell_in.channel];
    if (wr_en) begin
      mem[wr_ch] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      s2_v_r <= cell_valid;
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_ch] <= 1'b1;
      end
    end
  end

  // Forward a write to the same channel made while this cell was in stage 1
  always_ff @(posedge clk) begin
    s2_r       <= cell_in;
    s2_hit_r   <= wr_en && (wr_ch == cell_in.channel) && !clear;
    s2_fresh_r <= clear ||
                  !(valid_r[cell_in.channel] || (wr_en && wr_ch == cell_in.channel));
  end

  chmem_t fwd_r;
  always_ff @(posedge clk) begin
    fwd_r <= wr_data;
  end

  chmem_t m;
  always_comb begin
    if (s2_hit_r)        m = fwd_r;
    else if (s2_fresh_r) m = '0;
    else                 m = rd_r;
  end

  // Convert the cell
  logic [8:0] note, ins, vol, efx, d, nsum;
  logic       xfine, fvol, fine;
  logic [3:0] hi;
  chmem_t     nm;
  always_comb begin
    nm   = m;
    note = '0; ins = '0; vol = '0; efx = '0; d = '0;
    xfine = 1'b0; fvol = 1'b0; fine = 1'b0;
    hi   = '0;
    nsum = 9'd1 + {5'd0, s2_r.note_raw[3:0]} + 9'({s2_r.note_raw[7:4], 3'd0})
           + 9'({s2_r.note_raw[7:4], 2'd0});
    if (s2_r.mask[5]) begin
      ins = {1'b0, s2_r.instr_raw};
      if (ins > 9'(MAX_INSTRUMENT)) ins = '0;
      if (s2_r.note_raw == 8'd254)      note = 9'd97;
      else if (s2_r.note_raw == 8'd255) note = '0;
      else note = (nsum > 9'd96) ? 9'd0 : nsum;
    end
    if (s2_r.mask[6]) begin
      vol = (s2_r.vol_raw <= 8'd64) ? {1'b0, s2_r.vol_raw} + 9'h10 : 9'd0;
    end
    if (s2_r.mask[7]) begin
      efx = {1'b0, s2_r.effect_raw};
      d   = {1'b0, s2_r.param};
      if (d != 0) begin
        nm.last_param = d[7:0];
        if (efx == 9'd8 || efx == 9'd21) nm.last_vib = d[7:0];
      end
      if (d == 0 && efx != 9'd7) begin
        if (efx == 9'd8 || efx == 9'd21) d = {1'b0, m.last_vib};
        else if ((efx >= 9'd4 && efx <= 9'd12) || (efx >= 9'd17 && efx <= 9'd19))
          d = {1'b0, m.last_param};
        if (efx == {1'b0, m.last_effect} && efx != 9'd10 && efx != 9'd19) begin
          xfine = (efx == 9'd5 || efx == 9'd6) && (d[7:4] == 4'hE);
          fvol  = (efx == 9'd4 || efx == 9'd11) &&
                  ((d > 9'hF0) || ((d[3:0] == 4'hF) && (d[7:4] != 0)));
          if (!xfine && !fvol) d = '0;
        end
      end
      if (efx != 0) nm.last_effect = efx[7:0];
      case (efx)
        9'd1: begin
          efx = 9'hF;
          if (d == 0) efx = '0;
          else if (d > 9'h1F) d = 9'h1F;
        end
        9'd2: efx = 9'hB;
        9'd3: efx = 9'hD;
        9'd4, 9'd11: begin
          fine = 1'b1;
          if (d > 9'hF0) begin
            d = {1'b0, 4'hB, d[3:0]};
          end else if (d[3:0] == 4'hF && d[7:4] != 0) begin
            d = {1'b0, 4'hA, d[7:4]};
          end else begin
            fine = 1'b0;
            if (d[3:0] != 0) d = {5'd0, d[3:0]};
          end
          if (fine && efx == 9'd11 && vol == 0) vol = 9'hB0;
          efx = fine ? 9'hE : ((efx == 9'd4) ? 9'hA : 9'd6);
        end
        9'd5, 9'd6: begin
          // Extra fine only for an E high nibble, fine for F
          if (d[7:4] >= 4'hE) begin
            hi  = d[7:4];
            d   = {1'b0, (efx == 9'd5) ? 4'h2 : 4'h1, d[3:0]};
            efx = (hi == 4'hE) ? 9'h21 : 9'hE;
          end else begin
            efx = 9'd7 - efx;
          end
        end
        9'd7: begin
          efx = 9'd3;
          if (ins != 0 && ins[7:0] != m.last_porta_ins) ins = {1'b0, m.last_porta_ins};
        end
        9'd8:  efx = 9'd4;
        9'd9:  efx = 9'h1D;
        9'd10: efx = '0;
        9'd12: efx = 9'd5;
        9'd15: efx = 9'd9;
        9'd17: efx = 9'h1B;
        9'd18: efx = 9'd7;
        9'd19: begin
          hi  = d[7:4];
          efx = 9'hE;
          d   = {5'd0, d[3:0]};
          case (hi)
            4'h1: d[7:4] = 4'h3;
            4'h2: d[7:4] = 4'h5;
            4'h3: d[7:4] = 4'h4;
            4'h4: d[7:4] = 4'h7;
            4'h8: begin efx = 9'd8; d = {1'b0, d[3:0], d[3:0]}; end
            4'hB: d[7:4] = 4'h6;
            4'hC: begin
              d[7:4] = 4'hC;
              if (d[3:0] == 0) begin efx = '0; d = '0; end
            end
            4'hD: begin
              d[7:4] = 4'hD;
              if (note == 0 || note == 9'd97) begin efx = '0; d = '0; end
              else if (d[3:0] == 0) begin
                note = '0; ins = '0; vol = '0; efx = '0; d = '0;
              end
            end
            4'hE: d[7:4] = 4'hE;
            4'hF: d[7:4] = 4'hF;
            default: begin efx = '0; d = '0; end
          endcase
        end
        9'd20: begin
          efx = 9'hF;
          if (d < 9'h21) begin efx = '0; d = '0; end
        end
        9'd22: begin
          if (d > 9'h40) begin efx = '0; d = '0; end
          else efx = 9'h10;
        end
        9'd24: begin
          if (d > 9'h80) begin efx = '0; d = '0; end
          else begin
            efx = 9'd8;
            d   = (d == 9'h80) ? 9'd255 : {d[7:0], 1'b0};
          end
        end
        default: begin efx = '0; d = '0; end
      endcase
    end
    if (ins != 0 && efx != 9'd3) nm.last_porta_ins = ins[7:0];
  end

  assign wr_en   = s2_v_r && !clear;
  assign wr_ch   = s2_r.channel;
  assign wr_data = nm;

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    res_row           <= s2_r.row;
    res_channel       <= s2_r.channel;
    res_note          <= note[6:0];
    res_instrument    <= ins[7:0];
    res_volume        <= vol[7:0];
    res_effect        <= efx[5:0];
    res_param         <= d[7:0];
  end

endmodule
